FILE: rtl/adpcm_register_and_ram_writer_macros.svh
// Assertion macros shared by the ADPCM register writer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ADPCM_REGISTER_AND_RAM_WRITER_MACROS_SVH
`define ADPCM_REGISTER_AND_RAM_WRITER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ARW_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ARW_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/adpcm_rw_pkg.sv
// Package for the ADPCM register writer: register codes, sizes, result type.
// No dependencies.
package adpcm_rw_pkg;

  localparam int unsigned AddrW    = 21;
  localparam int unsigned RamBytes = 262144;
  localparam logic [AddrW:0] RAM_BYTES_W = (AddrW + 1)'(RamBytes);

  localparam logic [7:0] KEY_ON_MASK = 8'hA0;
  localparam logic [7:0] MEM_MASK    = 8'h60;
  localparam logic [7:0] PAN_MASK    = 8'hC0;
  localparam logic [4:0] FILL_WIDE   = 5'h1F;
  localparam logic [4:0] FILL_NARROW = 5'h03;

  typedef enum logic [3:0] {
    REG_CTRL1    = 4'h0,
    REG_CTRL2    = 4'h1,
    REG_START_LO = 4'h2,
    REG_START_HI = 4'h3,
    REG_STOP_LO  = 4'h4,
    REG_STOP_HI  = 4'h5,
    REG_PRESC_LO = 4'h6,
    REG_PRESC_HI = 4'h7,
    REG_DATA     = 4'h8,
    REG_DN_LO    = 4'h9,
    REG_DN_HI    = 4'hA,
    REG_LEVEL    = 4'hB,
    REG_LIMIT_LO = 4'hC,
    REG_LIMIT_HI = 4'hD,
    REG_SPARE_E  = 4'hE,
    REG_SPARE_F  = 4'hF
  } reg_code_t;

  typedef struct packed {
    logic             handled;
    logic             mem_write;
    logic [AddrW-1:0] mem_addr;
    logic [7:0]       mem_data;
    logic [AddrW-1:0] next_addr;
    logic             playing;
    logic [4:0]       key_on_volume;
    logic             pan_left;
    logic             pan_right;
    logic [15:0]      step_delta;
    logic [15:0]      prescale_value;
    logic [7:0]       volume_level;
  } result_t;

  // 16-bit register pair to byte address; wide = 32-byte units, else 4-byte
  function automatic logic [AddrW-1:0] addr_decode(input logic [15:0] v,
                                                   input logic wide,
                                                   input logic fill);
    logic [AddrW-1:0] a;
    a = wide ? {v, 5'b0} : {3'b0, v, 2'b0};
    if (fill) begin
      a = a | {16'b0, (wide ? FILL_WIDE : FILL_NARROW)};
    end
    return a;
  endfunction

endpackage

FILE: rtl/adpcm_rw_if.sv
// Handshake interfaces for the ADPCM register writer request and result.
// Depends on adpcm_rw_pkg.
interface adpcm_rw_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_index;
  logic [7:0] write_byte;

  modport source (output valid, reg_index, write_byte, input ready);
  modport sink   (input valid, reg_index, write_byte, output ready);
endinterface

interface adpcm_rw_rsp_if;
  import adpcm_rw_pkg::*;
  logic             valid;
  logic             ready;
  logic             handled;
  logic             mem_write;
  logic [AddrW-1:0] mem_addr;
  logic [7:0]       mem_data;
  logic [AddrW-1:0] next_addr;
  logic             playing;
  logic [4:0]       key_on_volume;
  logic             pan_left;
  logic             pan_right;
  logic [15:0]      step_delta;
  logic [15:0]      prescale_value;
  logic [7:0]       volume_level;

  modport source (output valid, handled, mem_write, mem_addr, mem_data, next_addr,
                  playing, key_on_volume, pan_left, pan_right, step_delta,
                  prescale_value, volume_level, input ready);
  modport sink   (input valid, handled, mem_write, mem_addr, mem_data, next_addr,
                  playing, key_on_volume, pan_left, pan_right, step_delta,
                  prescale_value, volume_level, output ready);
endinterface

FILE: rtl/adpcm_rw_core.sv
// Register file and decode state of the ADPCM unit; one write per step.
// Depends on adpcm_rw_pkg.
module adpcm_rw_core
  import adpcm_rw_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    reg_index,
  input  logic [7:0]    write_byte,
  output result_t       res
);

  logic [7:0]       shadow [16];
  logic [7:0]       control_one;
  logic [AddrW-1:0] start_address;
  logic [AddrW-1:0] stop_address;
  logic [AddrW-1:0] limit_address;
  logic [AddrW-1:0] pointer_address;
  logic             play_switch;
  logic [4:0]       key_volume;
  logic [7:0]       level_reg;
  logic [15:0]      rate_reg;
  logic [15:0]      prescale_reg;
  logic [1:0]       pan_bits;

  logic [7:0]       shadow_next [16];
  logic [7:0]       control_one_next;
  logic [AddrW-1:0] start_address_next;
  logic [AddrW-1:0] stop_address_next;
  logic [AddrW-1:0] limit_address_next;
  logic [AddrW-1:0] pointer_address_next;
  logic             play_switch_next;
  logic [4:0]       key_volume_next;
  logic [7:0]       level_reg_next;
  logic [15:0]      rate_reg_next;
  logic [15:0]      prescale_reg_next;
  logic [1:0]       pan_bits_next;

  logic             hit;
  logic             wide;
  logic             mem_write;
  reg_code_t        code;

  assign hit  = (reg_index[7:4] == 4'h0);
  assign code = reg_code_t'(reg_index[3:0]);
  // RAM-type bits of control 2 as held before this write
  assign wide = |shadow[1][1:0];

  always_comb begin
    shadow_next          = shadow;
    control_one_next     = control_one;
    start_address_next   = start_address;
    stop_address_next    = stop_address;
    limit_address_next   = limit_address;
    pointer_address_next = pointer_address;
    play_switch_next     = play_switch;
    key_volume_next      = key_volume;
    level_reg_next       = level_reg;
    rate_reg_next        = rate_reg;
    prescale_reg_next    = prescale_reg;
    pan_bits_next        = pan_bits;
    mem_write            = 1'b0;
    if (hit) begin
      shadow_next[reg_index[3:0]] = write_byte;
      case (code)
        REG_CTRL1: begin
          control_one_next = write_byte;
          if ((write_byte & KEY_ON_MASK) == KEY_ON_MASK) begin
            key_volume_next  = level_reg[7:3];
            play_switch_next = 1'b1;
          end
          if (write_byte[0]) begin
            key_volume_next  = 5'd0;
            play_switch_next = 1'b0;
          end
          if (!write_byte[7]) begin
            play_switch_next = 1'b0;
          end
        end
        REG_CTRL2: begin
          if ((write_byte & PAN_MASK) != 8'h00) begin
            pan_bits_next = write_byte[7:6];
          end
        end
        REG_START_LO, REG_START_HI: begin
          start_address_next   = addr_decode({shadow_next[3], shadow_next[2]}, wide, 1'b0);
          pointer_address_next = start_address_next;
        end
        REG_STOP_LO, REG_STOP_HI: begin
          stop_address_next = addr_decode({shadow_next[5], shadow_next[4]}, wide, 1'b1);
        end
        REG_PRESC_LO, REG_PRESC_HI: begin
          prescale_reg_next = {shadow_next[7], shadow_next[6]};
        end
        REG_DATA: begin
          if ((control_one & MEM_MASK) != 8'h00) begin
            mem_write = ({1'b0, pointer_address} < RAM_BYTES_W);
            if (stop_address > pointer_address) begin
              if (limit_address > pointer_address) begin
                pointer_address_next = pointer_address + AddrW'(1);
              end else begin
                pointer_address_next = '0;
              end
            end
          end
        end
        REG_DN_LO, REG_DN_HI: begin
          rate_reg_next = {shadow_next[10], shadow_next[9]};
        end
        REG_LEVEL: begin
          level_reg_next = write_byte;
        end
        REG_LIMIT_LO, REG_LIMIT_HI: begin
          limit_address_next = addr_decode({shadow_next[13], shadow_next[12]}, wide, 1'b1);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.handled        = hit;
    res.mem_write      = mem_write;
    res.mem_addr       = mem_write ? pointer_address : '0;
    res.mem_data       = mem_write ? write_byte : 8'h00;
    res.next_addr      = pointer_address_next;
    res.playing        = play_switch_next;
    res.key_on_volume  = key_volume_next;
    res.pan_left       = pan_bits_next[1];
    res.pan_right      = pan_bits_next[0];
    res.step_delta     = rate_reg_next;
    res.prescale_value = prescale_reg_next;
    res.volume_level   = level_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        shadow[i] <= 8'h00;
      end
      control_one     <= '0;
      start_address   <= '0;
      stop_address    <= '0;
      limit_address   <= '0;
      pointer_address <= '0;
      play_switch     <= 1'b0;
      key_volume      <= '0;
      level_reg       <= '0;
      rate_reg        <= '0;
      prescale_reg    <= '0;
      pan_bits        <= '0;
    end else if (step) begin
      shadow          <= shadow_next;
      control_one     <= control_one_next;
      start_address   <= start_address_next;
      stop_address    <= stop_address_next;
      limit_address   <= limit_address_next;
      pointer_address <= pointer_address_next;
      play_switch     <= play_switch_next;
      key_volume      <= key_volume_next;
      level_reg       <= level_reg_next;
      rate_reg        <= rate_reg_next;
      prescale_reg    <= prescale_reg_next;
      pan_bits        <= pan_bits_next;
    end
  end

endmodule

FILE: rtl/adpcm_register_and_ram_writer.sv
// Top level of the ADPCM register writer: input stage, core, result register.
// Depends on adpcm_rw_pkg, adpcm_rw_if, adpcm_rw_core and the assertion macros.
`include "adpcm_register_and_ram_writer_macros.svh"

// Takes one register write per item (register number, data byte) and returns
// one result item per write, in order. Registers 0-15 update a shadow file and
// the decoded control, address, pan, prescale, delta-N and level state; a
// data-register write with rec or mem set yields a sample-RAM store at the
// current pointer while it lies inside RAM. An accepted item waits in the input
// register; its decode and state update then land in the result register.
// Throughput is one item per cycle; the block keeps accepting while a result
// waits, stalling only when both the input stage and the result register are
// full and the receiver is not ready. No clearing pass after reset.
module adpcm_register_and_ram_writer
  import adpcm_rw_pkg::*;
(
  input logic           clk,
  input logic           rst,
  adpcm_rw_req_if.sink  req,
  adpcm_rw_rsp_if.source rsp
);

  // input stage
  logic       stage_valid;
  logic [7:0] stage_index;
  logic [7:0] stage_byte;

  // result register
  logic       out_valid;
  result_t    out_res;

  result_t    core_res;
  logic       move;

  // item leaves the input stage when the result register is free or draining
  assign move      = stage_valid && (!out_valid || rsp.ready);
  assign req.ready = !stage_valid || move;

  adpcm_rw_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (move),
    .reg_index  (stage_index),
    .write_byte (stage_byte),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_index <= req.reg_index;
      stage_byte  <= req.write_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_res <= core_res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.handled        = out_res.handled;
  assign rsp.mem_write      = out_res.mem_write;
  assign rsp.mem_addr       = out_res.mem_addr;
  assign rsp.mem_data       = out_res.mem_data;
  assign rsp.next_addr      = out_res.next_addr;
  assign rsp.playing        = out_res.playing;
  assign rsp.key_on_volume  = out_res.key_on_volume;
  assign rsp.pan_left       = out_res.pan_left;
  assign rsp.pan_right      = out_res.pan_right;
  assign rsp.step_delta     = out_res.step_delta;
  assign rsp.prescale_value = out_res.prescale_value;
  assign rsp.volume_level   = out_res.volume_level;

  // a step always leaves a result behind
  `ARW_ASSERT_NXT(a_move_fills_out, clk, rst, move, out_valid)
  // accepted item sits in the input stage next cycle
  `ARW_ASSERT_NXT(a_accept_fills_stage, clk, rst, req.valid && req.ready, stage_valid)
  // a blocked item is not dropped from the input stage
  `ARW_ASSERT_NXT(a_stage_holds, clk, rst, stage_valid && !move, stage_valid)
  // RAM stores only ever target addresses inside RAM, from a handled write
  `ARW_ASSERT_IMP(a_store_in_ram, clk, rst, out_valid && out_res.mem_write,
                  out_res.handled && ({1'b0, out_res.mem_addr} < RAM_BYTES_W))

endmodule

FILE: verif/tb_adpcm_register_and_ram_writer.sv
`timescale 1ns / 1ps
// Self-checking bench for adpcm_register_and_ram_writer: register writes in, one result per write.
// Depends on adpcm_rw_pkg, adpcm_rw_if and the block's RTL; needs no other file.
module tb_adpcm_register_and_ram_writer;
  import adpcm_rw_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 60;   // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 8;    // spare wait after the drain for stray results

  logic clk;
  logic rst;

  adpcm_rw_req_if req_bus ();
  adpcm_rw_rsp_if rsp_bus ();

  adpcm_register_and_ram_writer dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the unit's state, advanced once per accepted write
  // ---------------------------------------------------------------------------
  logic [7:0]       shadow_file [16] = '{default: 8'h00};
  logic [7:0]       ctl1_q      = '0;
  logic [AddrW-1:0] start_q     = '0;
  logic [AddrW-1:0] stop_q      = '0;
  logic [AddrW-1:0] limit_q     = '0;
  logic [AddrW-1:0] ptr_q       = '0;
  logic             play_q      = 1'b0;
  logic [4:0]       key_vol_q   = '0;
  logic [7:0]       level_q     = '0;
  logic [15:0]      delta_n_q   = '0;
  logic [15:0]      prescale_q  = '0;
  logic [1:0]       pan_q       = '0;   // [1] left, [0] right

  result_t pending_results[$];   // expected results, oldest first
  int      error_count  = 0;
  int      items_sent   = 0;     // handled writes only
  int      result_count = 0;
  int      cycle_count  = 0;

  // sender pacing and receiver hold-off control
  int burst_left    = 0;
  bit steady_send   = 1'b0;
  bit hold_request  = 1'b0;

  // Byte address of a register pair; the RAM-type bits of control 2 pick
  // 32-byte units (any bit set) or 4-byte units (both clear). Stop and limit
  // get their unit's low bits filled with ones.
  function automatic logic [AddrW-1:0] pair_to_byte_addr(input reg_code_t lo_reg,
                                                         input bit ones_fill);
    logic [15:0]      pair;
    logic             wide_units;
    logic [AddrW-1:0] a;
    pair       = {shadow_file[lo_reg + 4'd1], shadow_file[lo_reg]};
    wide_units = (shadow_file[REG_CTRL2][1:0] != 2'b00);
    a          = AddrW'(pair) << (wide_units ? 5 : 2);
    if (ones_fill) begin
      a = a | AddrW'(wide_units ? FILL_WIDE : FILL_NARROW);
    end
    return a;
  endfunction

  // Applies one register write to the shadow state and returns the result
  // the block must produce for it.
  function automatic result_t predict_write(input logic [7:0] idx, input logic [7:0] data);
    result_t res;
    res = '0;
    if (idx < 8'd16) begin
      res.handled = 1'b1;
      shadow_file[idx[3:0]] = data;
      case (reg_code_t'(idx[3:0]))
        REG_CTRL1: begin
          ctl1_q = data;
          if ((data & KEY_ON_MASK) == KEY_ON_MASK) begin
            key_vol_q = level_q[7:3];
            play_q    = 1'b1;
          end
          // reset bit wins over key-on
          if (data[0]) begin
            key_vol_q = '0;
            play_q    = 1'b0;
          end
          if (!data[7]) play_q = 1'b0;
        end
        REG_CTRL2: begin
          if ((data & PAN_MASK) != 8'h00) pan_q = data[7:6];
        end
        REG_START_LO, REG_START_HI: begin
          start_q = pair_to_byte_addr(REG_START_LO, 1'b0);
          ptr_q   = start_q;
        end
        REG_STOP_LO, REG_STOP_HI: stop_q = pair_to_byte_addr(REG_STOP_LO, 1'b1);
        REG_PRESC_LO, REG_PRESC_HI:
          prescale_q = {shadow_file[REG_PRESC_HI], shadow_file[REG_PRESC_LO]};
        REG_DATA: begin
          if ((ctl1_q & MEM_MASK) != 8'h00) begin
            // no store past the end of RAM, but the pointer update still applies
            if ({1'b0, ptr_q} < RAM_BYTES_W) begin
              res.mem_write = 1'b1;
              res.mem_addr  = ptr_q;
              res.mem_data  = data;
            end
            if (stop_q > ptr_q) ptr_q = (limit_q > ptr_q) ? ptr_q + 1'b1 : '0;
          end
        end
        REG_DN_LO, REG_DN_HI:
          delta_n_q = {shadow_file[REG_DN_HI], shadow_file[REG_DN_LO]};
        REG_LEVEL:   level_q = data;
        REG_LIMIT_LO, REG_LIMIT_HI: limit_q = pair_to_byte_addr(REG_LIMIT_LO, 1'b1);
        default: ;   // spare registers: shadow copy only
      endcase
    end
    res.next_addr      = ptr_q;
    res.playing        = play_q;
    res.key_on_volume  = key_vol_q;
    res.pan_left       = pan_q[1];
    res.pan_right      = pan_q[0];
    res.step_delta     = delta_n_q;
    res.prescale_value = prescale_q;
    res.volume_level   = level_q;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("adpcm_register_and_ram_writer: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps. Inputs change on the
  // falling edge; acceptance is judged on the rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] idx, input logic [7:0] data);
    int gap;
    if (!steady_send && burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        req_bus.valid      <= 1'b0;
        req_bus.reg_index  <= 8'($urandom);
        req_bus.write_byte <= 8'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    req_bus.valid      <= 1'b1;
    req_bus.reg_index  <= idx;
    req_bus.write_byte <= data;
    do @(posedge clk); while (!req_bus.ready);
    pending_results.push_back(predict_write(idx, data));
    if (idx < 8'd16) items_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  // write to one of the unit's own registers, by name
  task automatic send_reg(input reg_code_t code, input logic [7:0] data);
    send_item({4'h0, code}, data);
  endtask

  task automatic idle_sender();
    @(negedge clk);
    req_bus.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern switches every so often between always ready,
  // mostly ready, mostly stalled and a fixed 3-of-5 rhythm. A hold request
  // from the stimulus side drops ready for a long counted stretch.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int mode;
    int mode_left;
    int rhythm;
    mode      = 0;
    mode_left = 0;
    rhythm    = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        rhythm = (rhythm + 1) % 5;
        case (mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
          2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_bus.ready <= (rhythm < 3);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] result %0d: %s", $realtime, result_count, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no write outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("handled",        32'(rsp_bus.handled),        32'(want.handled));
        check_field("mem_write",      32'(rsp_bus.mem_write),      32'(want.mem_write));
        check_field("mem_addr",       32'(rsp_bus.mem_addr),       32'(want.mem_addr));
        check_field("mem_data",       32'(rsp_bus.mem_data),       32'(want.mem_data));
        check_field("next_addr",      32'(rsp_bus.next_addr),      32'(want.next_addr));
        check_field("playing",        32'(rsp_bus.playing),        32'(want.playing));
        check_field("key_on_volume",  32'(rsp_bus.key_on_volume),  32'(want.key_on_volume));
        check_field("pan_left",       32'(rsp_bus.pan_left),       32'(want.pan_left));
        check_field("pan_right",      32'(rsp_bus.pan_right),      32'(want.pan_right));
        check_field("step_delta",     32'(rsp_bus.step_delta),     32'(want.step_delta));
        check_field("prescale_value", 32'(rsp_bus.prescale_value),
                    32'(want.prescale_value));
        check_field("volume_level",   32'(rsp_bus.volume_level),   32'(want.volume_level));
      end
      result_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Register numbers above 15 change nothing and come back unhandled.
  task automatic test_unhandled_registers();
    send_item(8'd16, 8'hFF);
    send_item(8'd255, 8'h00);
  endtask

  // Pan with and without pan bits, prescale, delta-N, level, spare registers.
  task automatic test_register_decode();
    send_reg(REG_CTRL2, 8'hC3);     // both pans, 32-byte units
    send_reg(REG_CTRL2, 8'h03);     // no pan bits: pan stays
    send_reg(REG_CTRL2, 8'h40);     // right only, 4-byte units
    send_reg(REG_PRESC_LO, 8'hFF);
    send_reg(REG_PRESC_HI, 8'h80);
    send_reg(REG_DN_LO, 8'h01);
    send_reg(REG_DN_HI, 8'hFF);
    send_reg(REG_LEVEL, 8'hFF);
    send_reg(REG_SPARE_E, 8'hA5);
    send_reg(REG_SPARE_F, 8'h5A);
  endtask

  // Key-on latches level >> 3; reset bit overrides it; start clear stops.
  task automatic test_key_control();
    send_reg(REG_CTRL1, 8'hA0);
    send_reg(REG_CTRL1, 8'hA1);
    send_reg(REG_CTRL1, 8'hA0);
    send_reg(REG_CTRL1, 8'h20);
  endtask

  // Stores with the pointer walking up to the limit and wrapping to zero,
  // then a pointer beyond the end of RAM that moves without storing.
  task automatic test_sample_store();
    send_reg(REG_STOP_LO, 8'h01);    // stop = 7 in 4-byte units
    send_reg(REG_LIMIT_LO, 8'h00);   // limit = 3
    send_reg(REG_START_LO, 8'h00);
    send_reg(REG_CTRL1, 8'h60);
    repeat (5) send_reg(REG_DATA, 8'($urandom));
    send_reg(REG_CTRL2, 8'h03);      // 32-byte units
    send_reg(REG_START_HI, 8'hFF);   // pointer far past RAM
    send_reg(REG_DATA, 8'hFF);       // below stop fails: pointer holds
    send_reg(REG_STOP_HI, 8'hFF);
    send_reg(REG_DATA, 8'h00);       // above limit: wraps to zero
  endtask

  // ---------------------------------------------------------------------------
  // Random playback sequences: set up RAM type, start, stop and limit, turn on
  // rec/mem, then a run of data writes. Now and then stop sits below the
  // pointer or the start lies outside RAM.
  // ---------------------------------------------------------------------------
  task automatic run_playback_sequence();
    logic [15:0] start_units;
    logic [15:0] stop_units;
    logic [15:0] limit_units;
    logic [7:0]  ctl;
    bit          wide_units;
    int          n_data;
    if ($urandom_range(0, 2) == 0) send_reg(REG_CTRL2, 8'($urandom));
    wide_units = (shadow_file[REG_CTRL2][1:0] != 2'b00);
    if ($urandom_range(0, 7) == 0)
      start_units = 16'($urandom);
    else
      start_units = 16'($urandom_range(0, wide_units ? 16'h1FD0 : 16'hFFD0));
    stop_units  = start_units + 16'($urandom_range(0, 3) != 0 ?
                                    $urandom_range(0, 3) : $urandom_range(0, 40));
    limit_units = start_units + 16'($urandom_range(0, 3) != 0 ?
                                    $urandom_range(0, 3) : $urandom_range(0, 40));
    if ($urandom_range(0, 5) == 0) stop_units = start_units - 16'($urandom_range(1, 8));
    if ($urandom_range(0, 5) == 0) limit_units = 16'($urandom);

    if ($urandom_range(0, 3) != 0) begin
      send_reg(REG_STOP_LO, stop_units[7:0]);
      send_reg(REG_STOP_HI, stop_units[15:8]);
    end
    if ($urandom_range(0, 3) != 0) begin
      send_reg(REG_LIMIT_LO, limit_units[7:0]);
      send_reg(REG_LIMIT_HI, limit_units[15:8]);
    end
    send_reg(REG_START_LO, start_units[7:0]);
    send_reg(REG_START_HI, start_units[15:8]);
    if ($urandom_range(0, 3) == 0) send_reg(REG_LEVEL, 8'($urandom));
    if ($urandom_range(0, 5) == 0)
      send_item(8'($urandom_range(REG_PRESC_LO, REG_PRESC_HI)), 8'($urandom));
    if ($urandom_range(0, 5) == 0)
      send_item(8'($urandom_range(REG_DN_LO, REG_DN_HI)), 8'($urandom));

    ctl = 8'($urandom);
    if ($urandom_range(0, 4) != 0) ctl[6:5] = 2'($urandom_range(1, 3));
    if ($urandom_range(0, 3) == 0) ctl[0] = 1'b0;
    send_reg(REG_CTRL1, ctl);

    n_data = $urandom_range(1, 40);
    repeat (n_data) begin
      // occasional stray write in the middle of the run
      if ($urandom_range(0, 19) == 0)
        send_item(8'($urandom), 8'($urandom));
      send_reg(REG_DATA, 8'($urandom));
    end
  endtask

  task automatic test_random_sequences(input int target);
    while (items_sent < target) begin
      run_playback_sequence();
      repeat ($urandom_range(0, 2)) send_item(8'($urandom), 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Pressure
  // ---------------------------------------------------------------------------

  // Receiver holds off for a long stretch while writes keep coming, so the
  // block fills up and drops ready on its input.
  task automatic test_receiver_hold();
    steady_send  = 1'b1;
    hold_request = 1'b1;
    send_reg(REG_CTRL1, 8'h60);
    repeat (40) send_reg(REG_DATA, 8'($urandom));
    steady_send = 1'b0;
    burst_left  = 0;
  endtask

  // Sender stops until every outstanding result has come back.
  task automatic test_drain_pause();
    idle_sender();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                = 1'b1;
    req_bus.valid      = 1'b0;
    req_bus.reg_index  = 8'h00;
    req_bus.write_byte = 8'h00;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_unhandled_registers();
    test_register_decode();
    test_key_control();
    test_sample_store();
    test_receiver_hold();
    test_random_sequences(800);
    test_drain_pause();
    test_random_sequences(1600);

    // wind down: nothing outstanding, then a wait for stray results
    test_drain_pause();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("adpcm_register_and_ram_writer: match");
    end else begin
      $display("adpcm_register_and_ram_writer: mismatch");
    end
    $finish;
  end

endmodule
